// ----- rtl/cdo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cdo_pkg;

	localparam int YearW   = 12;
	localparam int MonthW  = 4;
	localparam int DayW    = 5;
	localparam int OffW    = 16;
	localparam int WdayW   = 3;
	localparam int SerialW = 21;
	localparam int SumW    = SerialW + 2;
	localparam int CycW    = 11;
	localparam int RemW    = 9;

	localparam int WeekLen        = 7;
	localparam int CommonYearDays = 365;
	localparam int LeapCycle      = 4;
	localparam int CycleDays      = LeapCycle * CommonYearDays + 1;
	localparam int YearLimit      = 4096;
	localparam int MonthsPerYear  = 12;

	// 2016-12-20 as a day count from 0000-01-01 (leap year, Jan..Nov = 335 days)
	localparam int EpochSerial = 2016 * CommonYearDays + (2016 + LeapCycle - 1) / LeapCycle
		+ 335 + 20 - 1;
	localparam int EpochMod    = EpochSerial % WeekLen;

	// Multiple of 7 that lifts the most negative shifted count above zero
	localparam int BiasDays    = WeekLen * ((2 ** (OffW - 1) + WeekLen) / WeekLen);
	localparam int MaxSerial   = YearLimit * CommonYearDays + YearLimit / LeapCycle - 1;

	// Reciprocal of 1461 scaled by 2^32, rounded up; exact for any 21-bit count
	localparam int RecipW      = 22;
	localparam int RecipShift  = 32;
	localparam int ProdW       = SerialW + RecipW;

	localparam logic [SerialW-1:0] BiasSerial = SerialW'(BiasDays);
	localparam logic [SerialW-1:0] HiLimit    = SerialW'(MaxSerial + BiasDays);
	localparam logic [RecipW-1:0]  CycleRecip = RecipW'(((64'd1 << RecipShift)
		+ 64'(CycleDays) - 64'd1) / 64'(CycleDays));
	localparam logic [WdayW-1:0]   EpochWday  = WdayW'(EpochMod);
	localparam logic [WdayW-1:0]   WrapWday   = WdayW'(WeekLen - EpochMod);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BASE,
		ST_MACC,
		ST_OFFS,
		ST_DIV,
		ST_REM,
		ST_YFIX,
		ST_MWALK,
		ST_DONE
	} cdo_state_t;

	function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] mo,
		input logic leap);
		logic [DayW-1:0] len;
		case (mo)
			4'd2: len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/cdo_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cdo_in_if;
	logic                     valid;
	logic                     ready;
	logic [11:0]              start_year;
	logic [3:0]               start_month;
	logic [4:0]               start_day;
	logic signed [15:0]       day_offset;

	modport source (output valid, start_year, start_month, start_day, day_offset,
		input ready);
	modport sink (input valid, start_year, start_month, start_day, day_offset,
		output ready);
endinterface

interface cdo_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] new_year;
	logic [3:0]  new_month;
	logic [4:0]  new_day;
	logic [2:0]  weekday;
	logic        year_out_of_range;

	modport source (output valid, new_year, new_month, new_day, weekday, year_out_of_range,
		input ready);
	modport sink (input valid, new_year, new_month, new_day, weekday, year_out_of_range,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/calendar_day_offset.sv -----
`timescale 1ns / 1ps
`default_nettype none

// calendar_day_offset
// Shifts a calendar date by a signed day count and gives the weekday of the
// result (0 is the weekday of 2016-12-20). Every year divisible by 4 is leap.
// Channels: in_ch (start_year/month/day, day_offset) and out_ch (new date,
// weekday, year_out_of_range), both valid/ready; a transfer happens on a
// rising clk edge with valid and ready high.
// After the input transfer the sequencer steps through BASE, MACC (up to the
// clamped start month, 1..12), OFFS, DIV, REM, YFIX, MWALK (over the whole
// months of the result year, 0..11) and DONE, then loads the output register.
// One item is in flight at a time; the sequencer steps one month-length adder
// per month loop, splits the count into four-year cycles by a reciprocal
// multiply by 1/1461 plus one back-multiply, and reduces the count modulo 7
// by folding its octal digits. in_ch.ready is high only while the sequencer
// is idle. A finished result sits in the output register; the next item is
// taken while it waits, and the sequencer holds in its last step if the
// previous result was not yet taken.
// Out-of-range years saturate to 0000-01-01 or 4095-12-31 with the flag set.
// Reset (arst_n low) empties the sequencer and drops any pending result.
module calendar_day_offset (
	input  wire logic clk,
	input  wire logic arst_n,
	cdo_in_if.sink    in_ch,
	cdo_out_if.source out_ch
);
	import cdo_pkg::*;

	cdo_state_t state_q, state_d;

	// Captured item
	logic [YearW-1:0]   year_q;
	logic [MonthW-1:0]  month_q;
	logic [DayW-1:0]    day_q;
	logic [OffW-1:0]    off_q;

	// Working registers
	logic [SerialW-1:0] acc_q;    // day count of the start date, first of month
	logic [MonthW-1:0]  idx_q;    // month index for both month loops
	logic [SerialW-1:0] b_q;      // biased count, source of the weekday
	logic [SerialW-1:0] s_q;      // true day count
	logic [CycW-1:0]    quo_q;    // whole four-year cycles
	logic [CycW-1:0]    rem_q;    // days into the four-year cycle
	logic [WdayW-1:0]   m7_q;
	logic               lo_q, hi_q;
	logic [YearW-1:0]   yr_q;
	logic [RemW-1:0]    r_q;

	// Output register
	logic               ovalid_q;
	logic [YearW-1:0]   oyear_q;
	logic [MonthW-1:0]  omonth_q;
	logic [DayW-1:0]    oday_q;
	logic [WdayW-1:0]   owday_q;
	logic               oflag_q;

	logic               take_in, load_out;
	logic               macc_more, walk_more;
	logic [DayW-1:0]    macc_len, walk_len;
	logic [MonthW-1:0]  month_clamp;
	logic [SumW-1:0]    sum;
	logic [SerialW-1:0] base_cnt;
	logic [ProdW-1:0]   quo_prod;
	logic [SerialW-1:0] rem_full;
	logic [5:0]         m7_f1;
	logic [3:0]         m7_f2;
	logic [WdayW-1:0]   m7_fold;
	logic [CycW-1:0]    yf_r1, yf_r2;
	logic [1:0]         yf_add;
	logic [WdayW-1:0]   wday;

	assign take_in = in_ch.valid && in_ch.ready;

	// Clamp the month into 1..12
	always_comb begin
		if (in_ch.start_month == '0) begin
			month_clamp = MonthW'(1);
		end else if (in_ch.start_month > MonthW'(MonthsPerYear)) begin
			month_clamp = MonthW'(MonthsPerYear);
		end else begin
			month_clamp = in_ch.start_month;
		end
	end

	// Days before the year: 365 * y plus the leap years strictly below y
	assign base_cnt = SerialW'(year_q) * SerialW'(CommonYearDays)
		+ SerialW'(year_q[YearW-1:2]) + SerialW'(year_q[1:0] != 2'b00);

	assign macc_len  = month_len(idx_q, year_q[1:0] == 2'b00);
	assign macc_more = idx_q < month_q;

	// Add day - 1, the signed offset and the bias in one wide add
	assign sum = SumW'(acc_q) + SumW'(day_q) - SumW'(1)
		+ {{(SumW - OffW){off_q[OffW-1]}}, off_q} + SumW'(BiasSerial);

	// Four-year cycles: quotient by reciprocal multiply, remainder by back-multiply
	assign quo_prod = ProdW'(s_q) * ProdW'(CycleRecip);
	assign rem_full = s_q - SerialW'(quo_q) * SerialW'(CycleDays);

	// Modulo 7: 8 is 1 mod 7, so sum the octal digits, fold once more, then trim
	always_comb begin
		m7_f1 = '0;
		for (int k = 0; k < SerialW / 3; k++) begin
			m7_f1 = m7_f1 + 6'(b_q[3*k +: 3]);
		end
		m7_f2   = 4'(m7_f1[5:3]) + 4'(m7_f1[2:0]);
		m7_fold = (m7_f2 >= 4'(WeekLen)) ? WdayW'(m7_f2 - 4'(WeekLen))
			: m7_f2[WdayW-1:0];
	end

	// Year within the four-year cycle: first year is leap with 366 days
	always_comb begin
		yf_r1  = rem_q - CycW'(CommonYearDays + 1);
		yf_add = 2'd0;
		yf_r2  = rem_q;
		if (rem_q >= CycW'(CommonYearDays + 1)) begin
			if (yf_r1 >= CycW'(2 * CommonYearDays)) begin
				yf_add = 2'd3;
				yf_r2  = yf_r1 - CycW'(2 * CommonYearDays);
			end else if (yf_r1 >= CycW'(CommonYearDays)) begin
				yf_add = 2'd2;
				yf_r2  = yf_r1 - CycW'(CommonYearDays);
			end else begin
				yf_add = 2'd1;
				yf_r2  = yf_r1;
			end
		end
	end

	assign walk_len  = month_len(idx_q, yr_q[1:0] == 2'b00);
	assign walk_more = (idx_q < MonthW'(MonthsPerYear)) && (r_q >= RemW'(walk_len));

	assign wday = (m7_q >= EpochWday) ? m7_q - EpochWday : m7_q + WrapWday;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		load_out    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					state_d = ST_BASE;
				end
			end
			ST_BASE:  state_d = ST_MACC;
			ST_MACC: begin
				if (!macc_more) begin
					state_d = ST_OFFS;
				end
			end
			ST_OFFS:  state_d = ST_DIV;
			ST_DIV:   state_d = ST_REM;
			ST_REM:   state_d = ST_YFIX;
			ST_YFIX:  state_d = ST_MWALK;
			ST_MWALK: begin
				if (!walk_more) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// Hold until the output register is free
				if (!ovalid_q || out_ch.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (take_in) begin
					year_q  <= in_ch.start_year;
					month_q <= month_clamp;
					day_q   <= in_ch.start_day;
					off_q   <= in_ch.day_offset;
					idx_q   <= MonthW'(1);
				end
			end
			ST_BASE: acc_q <= base_cnt;
			ST_MACC: begin
				if (macc_more) begin
					acc_q <= acc_q + SerialW'(macc_len);
					idx_q <= idx_q + MonthW'(1);
				end
			end
			ST_OFFS: begin
				b_q  <= sum[SerialW-1:0];
				s_q  <= sum[SerialW-1:0] - BiasSerial;
				lo_q <= sum[SerialW-1:0] < BiasSerial;
				hi_q <= sum[SerialW-1:0] > HiLimit;
			end
			ST_DIV: begin
				quo_q <= quo_prod[ProdW-1:RecipShift];
				m7_q  <= m7_fold;
			end
			ST_REM: rem_q <= rem_full[CycW-1:0];
			ST_YFIX: begin
				yr_q  <= {quo_q[YearW-3:0], 2'b00} + YearW'(yf_add);
				r_q   <= yf_r2[RemW-1:0];
				idx_q <= MonthW'(1);
			end
			ST_MWALK: begin
				if (walk_more) begin
					r_q   <= r_q - RemW'(walk_len);
					idx_q <= idx_q + MonthW'(1);
				end
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	// Output register: payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			owday_q <= wday;
			oflag_q <= lo_q || hi_q;
			if (lo_q) begin
				oyear_q  <= '0;
				omonth_q <= MonthW'(1);
				oday_q   <= DayW'(1);
			end else if (hi_q) begin
				oyear_q  <= YearW'(YearLimit - 1);
				omonth_q <= MonthW'(MonthsPerYear);
				oday_q   <= DayW'(31);
			end else begin
				oyear_q  <= yr_q;
				omonth_q <= idx_q;
				oday_q   <= r_q[DayW-1:0] + DayW'(1);
			end
		end
	end

	// Output register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (load_out) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	assign out_ch.valid             = ovalid_q;
	assign out_ch.new_year          = oyear_q;
	assign out_ch.new_month         = omonth_q;
	assign out_ch.new_day           = oday_q;
	assign out_ch.weekday           = owday_q;
	assign out_ch.year_out_of_range = oflag_q;

	// A flagged result carries one of the two saturated dates
	a_sat_date: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && oflag_q) |->
			((oyear_q == '0 && omonth_q == MonthW'(1) && oday_q == DayW'(1)) ||
			 (oyear_q == YearW'(YearLimit - 1) && omonth_q == MonthW'(MonthsPerYear)
			  && oday_q == DayW'(31))))
		else $error("saturated date wrong");

	// Every delivered month and weekday stay in range, and the day is at least 1
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> (omonth_q >= MonthW'(1) && omonth_q <= MonthW'(MonthsPerYear)
			&& oday_q >= DayW'(1) && owday_q < WdayW'(WeekLen)))
		else $error("result field out of range");

	// A stalled result holds valid and payload until it transfers
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !out_ch.ready) |=> (ovalid_q && $stable(oyear_q)
			&& $stable(omonth_q) && $stable(oday_q) && $stable(owday_q)
			&& $stable(oflag_q)))
		else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- tb/tb_calendar_day_offset.sv -----
`timescale 1ns / 1ps

// Self-checking bench: every transfer on the input channel is run through a
// behavioral date shifter, and every transfer on the output channel is compared
// against the oldest pending prediction.
module tb_calendar_day_offset;

	import cdo_pkg::*;

	// Calendar constants of the behavioral shifter (every fourth year is leap)
	localparam longint YEAR_DAYS   = 365;
	localparam longint QUAD_DAYS   = 4 * YEAR_DAYS + 1;
	// 2016-12-20 as a day count from 0000-01-01: Jan..Nov of a leap year is 335 days
	localparam longint EPOCH_COUNT = 2016 * YEAR_DAYS + (2016 + 3) / 4 + 335 + 20 - 1;
	// Last representable day, 4095-12-31
	localparam longint LAST_COUNT  = 4096 * YEAR_DAYS + (4096 + 3) / 4 - 1;
	localparam int     LONG_HOLD   = 250;
	localparam int     SHOW_LIMIT  = 10;

	typedef struct packed {
		logic [YearW-1:0]  year;
		logic [MonthW-1:0] month;
		logic [DayW-1:0]   day;
		logic [OffW-1:0]   offset;
	} date_req_t;

	typedef struct packed {
		logic [YearW-1:0]  year;
		logic [MonthW-1:0] month;
		logic [DayW-1:0]   day;
		logic [WdayW-1:0]  weekday;
		logic              out_of_range;
	} date_res_t;

	logic clk = 1'b0;
	logic arst_n;

	cdo_in_if  in_bus ();
	cdo_out_if out_bus ();

	calendar_day_offset dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_bus),
		.out_ch (out_bus)
	);

	always #4 clk = ~clk;

	date_req_t pending_dates[$];
	date_res_t expected_dates[$];

	int mismatch_count = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit send_pause     = 1'b0;
	int holds_wanted   = 0;
	int holds_started  = 0;
	int hold_left      = 0;

	// ------------------------------------------------------------------
	// Behavioral date shifter
	// ------------------------------------------------------------------
	function automatic int days_in_month(longint yr, int mo);
		if (mo == 2) begin
			return (yr % 4 == 0) ? 29 : 28;
		end
		case (mo)
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	// Day count from 0000-01-01; the day is taken linearly from the first of
	// the month, so day 0 and days past the month end simply roll over.
	function automatic longint day_count(longint yr, int mo, longint dy);
		longint cnt;
		int     i;
		cnt = yr * YEAR_DAYS + (yr + 3) / 4;
		for (i = 1; i < mo; i++) begin
			cnt += days_in_month(yr, i);
		end
		return cnt + dy - 1;
	endfunction

	function automatic date_res_t shift_date(date_req_t req);
		date_res_t res;
		longint    cnt;
		longint    wd;
		longint    quad;
		longint    rem;
		longint    yr;
		int        mo;
		// Clamp the start month into 1..12
		mo = int'(req.month);
		if (mo < 1) mo = 1;
		if (mo > 12) mo = 12;
		cnt = day_count(longint'(req.year), mo, longint'(req.day))
			+ longint'($signed(req.offset));

		// Weekday follows the true count, even when the date saturates
		wd = (cnt - EPOCH_COUNT) % 7;
		if (wd < 0) wd += 7;
		res.weekday = WdayW'(wd);

		if (cnt < 0) begin
			res.year = '0;
			res.month = MonthW'(1);
			res.day = DayW'(1);
			res.out_of_range = 1'b1;
		end else if (cnt > LAST_COUNT) begin
			res.year = YearW'(4095);
			res.month = MonthW'(12);
			res.day = DayW'(31);
			res.out_of_range = 1'b1;
		end else begin
			// Split into four-year cycles, then years inside the cycle
			quad = cnt / QUAD_DAYS;
			rem = cnt % QUAD_DAYS;
			yr = quad * 4;
			if (rem >= YEAR_DAYS + 1) begin
				rem -= YEAR_DAYS + 1;
				yr += 1 + rem / YEAR_DAYS;
				rem = rem % YEAR_DAYS;
			end
			// Walk whole months of the result year
			mo = 1;
			while (mo < 12 && rem >= days_in_month(yr, mo)) begin
				rem -= days_in_month(yr, mo);
				mo++;
			end
			res.year = YearW'(yr);
			res.month = MonthW'(mo);
			res.day = DayW'(rem + 1);
			res.out_of_range = 1'b0;
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------
	function automatic date_req_t make_date(int yr, int mo, int dy, int off);
		date_req_t req;
		req.year = YearW'(yr);
		req.month = MonthW'(mo);
		req.day = DayW'(dy);
		req.offset = OffW'(off);
		return req;
	endfunction

	// Append one item to the tail of the send queue
	function automatic void add_date(date_req_t req);
		pending_dates.insert(pending_dates.size(), req);
	endfunction

	// Mostly well-formed dates; the rest uses any month and day codes.
	// Bias years toward both ends of the range so that saturation is hit.
	function automatic date_req_t random_date();
		date_req_t req;
		int        yr;
		int        mo;
		int        dy;
		int        off;
		case ($urandom_range(9))
			0: yr = $urandom_range(95);
			1: yr = $urandom_range(4095, 4000);
			2: yr = $urandom_range(2040, 1990);
			default: yr = $urandom_range(4095);
		endcase
		if ($urandom_range(99) < 80) begin
			mo = $urandom_range(12, 1);
			dy = $urandom_range(days_in_month(yr, mo), 1);
		end else begin
			mo = $urandom_range(15);
			dy = $urandom_range(31);
		end
		case ($urandom_range(9))
			0: off = int'($urandom_range(80)) - 40;
			1: begin
				case ($urandom_range(3))
					0: off = -32768;
					1: off = -32767;
					2: off = 32766;
					default: off = 32767;
				endcase
			end
			2: off = int'($urandom_range(800)) - 400;
			default: off = int'($urandom_range(65535)) - 32768;
		endcase
		req = make_date(yr, mo, dy, off);
		return req;
	endfunction

	task automatic queue_random(int count);
		repeat (count) add_date(random_date());
	endtask

	// Edge cases: epoch, range ends, leap rules, month clamp, day rollover
	task automatic queue_directed();
		add_date(make_date(2016, 12, 20, 0));
		add_date(make_date(0, 1, 1, 0));
		add_date(make_date(0, 1, 1, -1));
		add_date(make_date(0, 1, 1, -32768));
		add_date(make_date(0, 1, 1, 32767));
		add_date(make_date(4095, 12, 31, 0));
		add_date(make_date(4095, 12, 31, 1));
		add_date(make_date(4095, 12, 31, 32767));
		add_date(make_date(4095, 12, 31, -32768));
		add_date(make_date(2000, 2, 28, 1));
		add_date(make_date(2100, 2, 28, 1));
		add_date(make_date(2019, 2, 28, 1));
		add_date(make_date(2016, 0, 15, 0));
		add_date(make_date(2016, 13, 31, 0));
		add_date(make_date(2016, 15, 10, 0));
		add_date(make_date(2017, 3, 0, 0));
		add_date(make_date(2016, 2, 31, 0));
		add_date(make_date(2016, 4, 31, 0));
		add_date(make_date(2016, 12, 31, 1));
		add_date(make_date(2017, 1, 1, -1));
		add_date(make_date(2016, 1, 1, 366));
		add_date(make_date(0, 2, 29, 0));
		add_date(make_date(3, 12, 31, 1));
		add_date(make_date(4095, 15, 31, -1));
		add_date(make_date(4095, 1, 1, -32768));
	endtask

	// Hold until every queued item is sent and every prediction is checked
	task automatic wait_drained();
		while (pending_dates.size() != 0 || in_bus.valid || expected_dates.size() != 0)
			@(negedge clk);
	endtask

	// Set idle rates on the falling edge so the clocked processes see them cleanly
	task automatic set_idling(int send_pct, int recv_pct);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// ------------------------------------------------------------------
	// Input driver: offer queued items, predict each transfer
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_inputs
		date_req_t taken;
		date_req_t nxt;
		if (!arst_n) begin
			in_bus.valid <= 1'b0;
			in_bus.start_year <= '0;
			in_bus.start_month <= '0;
			in_bus.start_day <= '0;
			in_bus.day_offset <= '0;
		end else begin
			// Predict the item that transfers on this edge
			if (in_bus.valid && in_bus.ready) begin
				taken.year = in_bus.start_year;
				taken.month = in_bus.start_month;
				taken.day = in_bus.start_day;
				taken.offset = in_bus.day_offset;
				expected_dates.insert(expected_dates.size(), shift_date(taken));
			end
			// Hold an offered item until it transfers; otherwise pick the next one
			if (!in_bus.valid || in_bus.ready) begin
				if (pending_dates.size() != 0 && !send_pause
					&& $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_dates.pop_front();
					in_bus.valid <= 1'b1;
					in_bus.start_year <= nxt.year;
					in_bus.start_month <= nxt.month;
					in_bus.start_day <= nxt.day;
					in_bus.day_offset <= nxt.offset;
				end else begin
					in_bus.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Long receiver hold-off, counted in cycles
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_started < holds_wanted) begin
			hold_left <= LONG_HOLD;
			holds_started <= holds_started + 1;
		end
	end

	// Receiver ready: drop during a hold-off, else stall at the phase rate
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_bus.ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_bus.ready <= 1'b0;
		end else begin
			out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Output monitor: compare every transfer with the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_outputs
		date_res_t want;
		date_res_t got;
		if (arst_n && out_bus.valid && out_bus.ready) begin
			got.year = out_bus.new_year;
			got.month = out_bus.new_month;
			got.day = out_bus.new_day;
			got.weekday = out_bus.weekday;
			got.out_of_range = out_bus.year_out_of_range;
			if (expected_dates.size() == 0) begin
				mismatch_count <= mismatch_count + 1;
				if (mismatch_count < SHOW_LIMIT)
					$display("unexpected result %0d-%0d-%0d wd %0d oor %0d",
						got.year, got.month, got.day, got.weekday, got.out_of_range);
			end else begin
				want = expected_dates.pop_front();
				if (got.year !== want.year || got.month !== want.month
					|| got.day !== want.day || got.weekday !== want.weekday
					|| got.out_of_range !== want.out_of_range) begin
					mismatch_count <= mismatch_count + 1;
					if (mismatch_count < SHOW_LIMIT)
						$display("mismatch: expected %0d-%0d-%0d wd %0d oor %0d, got %0d-%0d-%0d wd %0d oor %0d",
							want.year, want.month, want.day, want.weekday,
							want.out_of_range, got.year, got.month, got.day,
							got.weekday, got.out_of_range);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence of phases
	// ------------------------------------------------------------------
	initial begin
		// Hold reset; the clocked processes clear the channel signals
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// No idling: directed cases, then random items under a long hold-off
		// so the block fills up and stalls its input
		set_idling(0, 0);
		queue_directed();
		queue_random(350);
		holds_wanted = 1;
		wait_drained();

		// Sender idle most cycles; pause halfway until every result is back
		set_idling(70, 0);
		queue_random(360);
		while (pending_dates.size() > 180) @(negedge clk);
		send_pause = 1'b1;
		while (in_bus.valid || expected_dates.size() != 0) @(negedge clk);
		send_pause = 1'b0;
		wait_drained();

		// Receiver stalling most cycles
		set_idling(0, 70);
		queue_random(360);
		wait_drained();

		// Light idling on both sides
		set_idling(8, 8);
		queue_random(360);
		wait_drained();

		// Let any stray result surface before the verdict
		repeat (60) @(negedge clk);
		if (mismatch_count == 0 && expected_dates.size() == 0) begin
			$display("PASS calendar_day_offset");
		end else begin
			$display("FAIL calendar_day_offset");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#6_000_000;
		$display("FAIL calendar_day_offset");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/cdo_pkg.sv
rtl/cdo_if.sv
rtl/calendar_day_offset.sv
tb/tb_calendar_day_offset.sv
